// ----- design/cubeh_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubeh_pkg
// Types and constants for the CubeHash r=1 b=1 h=256 core.
// ----------------------------------------------------------------------------
`default_nettype none

package cubeh_pkg;

    localparam int WORD_W     = 32;
    localparam int CUBE_WORDS = 32;
    localparam int HALF_WORDS = 16;
    localparam int IDX_W      = 4;

    typedef logic [WORD_W-1:0]     t_word;
    typedef t_word [CUBE_WORDS-1:0] t_cube;

    // rotation and swap masks of the two half-rounds
    localparam int               ROT_A     = 7;
    localparam int               ROT_B     = 11;
    localparam logic [IDX_W-1:0] SWAP_LO_A = 4'd8;
    localparam logic [IDX_W-1:0] SWAP_HI_A = 4'd2;
    localparam logic [IDX_W-1:0] SWAP_LO_B = 4'd4;
    localparam logic [IDX_W-1:0] SWAP_HI_B = 4'd1;

    // starting words of the initial vector
    localparam t_word IV_W0 = 32'd32;
    localparam t_word IV_W1 = 32'd1;
    localparam t_word IV_W2 = 32'd1;

    localparam logic [7:0] PAD_BYTE = 8'd128;

    // half-round counts
    localparam int             CNT_W      = 5;
    localparam logic [CNT_W-1:0] HALVES_ONE = 5'd2;
    localparam logic [CNT_W-1:0] HALVES_TEN = 5'd20;

    localparam logic CMD_ABSORB = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [7:0] msg_byte;
    } t_in_item;

    typedef struct packed {
        logic [63:0] digest_word0;
        logic [63:0] digest_word1;
        logic [63:0] digest_word2;
        logic [63:0] digest_word3;
    } t_out_item;

endpackage

`default_nettype wire

// ----- design/cubeh_half_round.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubeh_half_round
// Shared half-round unit: add low into high, rotate and swap low, XOR high
// into low, swap high. i_phase selects the first or second half of a round.
// ----------------------------------------------------------------------------
`default_nettype none

module cubeh_half_round (
    input  wire logic                i_phase,
    input  wire cubeh_pkg::t_cube    i_cube,
    output cubeh_pkg::t_cube         o_cube
);

    cubeh_pkg::t_word [cubeh_pkg::HALF_WORDS-1:0] w_sum;
    cubeh_pkg::t_word [cubeh_pkg::HALF_WORDS-1:0] w_rot;
    logic [cubeh_pkg::IDX_W-1:0]                  w_swap_lo;
    logic [cubeh_pkg::IDX_W-1:0]                  w_swap_hi;

    assign w_swap_lo = i_phase ? cubeh_pkg::SWAP_LO_B : cubeh_pkg::SWAP_LO_A;
    assign w_swap_hi = i_phase ? cubeh_pkg::SWAP_HI_B : cubeh_pkg::SWAP_HI_A;

    always_comb begin
        for (int i = 0; i < cubeh_pkg::HALF_WORDS; i++) begin
            w_sum[i] = i_cube[i + cubeh_pkg::HALF_WORDS] + i_cube[i];
            if (i_phase) begin
                w_rot[i] = (i_cube[i] << cubeh_pkg::ROT_B)
                         | (i_cube[i] >> (cubeh_pkg::WORD_W - cubeh_pkg::ROT_B));
            end else begin
                w_rot[i] = (i_cube[i] << cubeh_pkg::ROT_A)
                         | (i_cube[i] >> (cubeh_pkg::WORD_W - cubeh_pkg::ROT_A));
            end
        end
    end

    always_comb begin
        for (int j = 0; j < cubeh_pkg::HALF_WORDS; j++) begin
            o_cube[j] = w_rot[cubeh_pkg::IDX_W'(j) ^ w_swap_lo] ^ w_sum[j];
            o_cube[j + cubeh_pkg::HALF_WORDS] = w_sum[cubeh_pkg::IDX_W'(j) ^ w_swap_hi];
        end
    end

endmodule

`default_nettype wire

// ----- design/cubehash_r1_b1_256.sv -----
`timescale 1ns / 1ps
// Absorb item: after the accept cycle, two half-round unit passes, one pass per cycle.
// Finish item: a padded round and the final rounds to the digest, then rounds to rebuild the IV;
// the last final pass waits while a previous digest is still stalled.
// A new absorb item is taken only after the accept cycle and both passes of the last one.
// Reset: IV generation runs with input stalled before the first item.
// ----------------------------------------------------------------------------
// cubehash_r1_b1_256
// CubeHash r=1 b=1 h=256 with an iterative half-round unit and sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module cubehash_r1_b1_256 (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire cubeh_pkg::t_in_item   i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output cubeh_pkg::t_out_item       o_out_data
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    localparam logic [1:0] MODE_IV     = 2'd0;
    localparam logic [1:0] MODE_ABSORB = 2'd1;
    localparam logic [1:0] MODE_PAD    = 2'd2;
    localparam logic [1:0] MODE_FINAL  = 2'd3;

    logic                          r_fsm,  n_fsm;
    logic [1:0]                    r_mode, n_mode;
    logic [cubeh_pkg::CNT_W-1:0]   r_cnt,  n_cnt;
    logic                          r_half, n_half;
    cubeh_pkg::t_cube              r_cube, n_cube;
    logic                          r_out_valid, n_out_valid;
    cubeh_pkg::t_out_item          r_out_data,  n_out_data;

    cubeh_pkg::t_cube w_round;
    cubeh_pkg::t_cube w_base;
    logic             w_accept;
    logic             w_last;
    logic             w_out_free;

    cubeh_half_round u_half_round (
        .i_phase (r_half),
        .i_cube  (r_cube),
        .o_cube  (w_round)
    );

    always_comb begin
        w_base    = '0;
        w_base[0] = cubeh_pkg::IV_W0;
        w_base[1] = cubeh_pkg::IV_W1;
        w_base[2] = cubeh_pkg::IV_W2;
    end

    assign o_in_stall  = (r_fsm != ST_IDLE);
    assign w_accept    = i_in_valid && (r_fsm == ST_IDLE);
    assign w_last      = (r_cnt == cubeh_pkg::CNT_W'(1));
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        n_fsm       = r_fsm;
        n_mode      = r_mode;
        n_cnt       = r_cnt;
        n_half      = r_half;
        n_cube      = r_cube;
        n_out_data  = r_out_data;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_fsm)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_in_data.cmd == cubeh_pkg::CMD_FINISH) begin
                        n_cube[0][7:0] = r_cube[0][7:0] ^ cubeh_pkg::PAD_BYTE;
                        n_mode         = MODE_PAD;
                    end else begin
                        n_cube[0][7:0] = r_cube[0][7:0] ^ i_in_data.msg_byte;
                        n_mode         = MODE_ABSORB;
                    end
                    n_cnt  = cubeh_pkg::HALVES_ONE;
                    n_half = 1'b0;
                    n_fsm  = ST_RUN;
                end
            end
            ST_RUN: begin
                if (!(w_last && (r_mode == MODE_FINAL) && !w_out_free)) begin
                    n_cube = w_round;
                    n_half = ~r_half;
                    n_cnt  = r_cnt - cubeh_pkg::CNT_W'(1);
                    if (w_last) begin
                        n_half = 1'b0;
                        unique case (r_mode) inside
                            MODE_IV, MODE_ABSORB: begin
                                n_fsm = ST_IDLE;
                            end
                            MODE_PAD: begin
                                n_cube[31][0] = ~w_round[31][0];
                                n_cnt         = cubeh_pkg::HALVES_TEN;
                                n_mode        = MODE_FINAL;
                            end
                            MODE_FINAL: begin
                                n_out_data.digest_word0 = {w_round[1], w_round[0]};
                                n_out_data.digest_word1 = {w_round[3], w_round[2]};
                                n_out_data.digest_word2 = {w_round[5], w_round[4]};
                                n_out_data.digest_word3 = {w_round[7], w_round[6]};
                                n_out_valid             = 1'b1;
                                n_cube                  = w_base;
                                n_cnt                   = cubeh_pkg::HALVES_TEN;
                                n_mode                  = MODE_IV;
                            end
                            default: begin
                                n_fsm = ST_IDLE;
                            end
                        endcase
                    end
                end
            end
            default: begin
                n_fsm = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= ST_RUN;
            r_mode      <= MODE_IV;
            r_cnt       <= cubeh_pkg::HALVES_TEN;
            r_half      <= 1'b0;
            r_cube      <= w_base;
            r_out_valid <= 1'b0;
        end else begin
            r_fsm       <= n_fsm;
            r_mode      <= n_mode;
            r_cnt       <= n_cnt;
            r_half      <= n_half;
            r_cube      <= n_cube;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

endmodule

`default_nettype wire

// ----- tb/tb_cubehash_r1_b1_256.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cubehash_r1_b1_256
// Self-checking bench for the CubeHash r=1 b=1 h=256 core. A scoreboard class
// keeps its own 1024-bit cube, absorbs every accepted byte, and queues the
// digest expected on each finish. Messages of random length and content are
// pushed through with random gaps on the input side, random stall on the
// output side, and one long output hold-off per phase so the core backs up.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_cubehash_r1_b1_256;

    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 3;
    localparam int ITEM_TARGET    = 2000;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 64;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PRINT_CAP      = 40;
    localparam int IV_ROUNDS      = 10;
    localparam int FINAL_ROUNDS   = 10;

    class digest_scoreboard;
        bit [31:0]            cube[cubeh_pkg::CUBE_WORDS];
        cubeh_pkg::t_out_item pending[$];
        int unsigned          errors;

        function new();
            errors = 0;
            load_iv();
        endfunction

        function bit [31:0] rotl(bit [31:0] v, int unsigned s);
            return (v << s) | (v >> (32 - s));
        endfunction

        function void half_round(int unsigned rot, int unsigned swap_lo,
                                 int unsigned swap_hi);
            bit [31:0] tmp[cubeh_pkg::HALF_WORDS];
            for (int i = 0; i < cubeh_pkg::HALF_WORDS; i++)
                cube[i + cubeh_pkg::HALF_WORDS] += cube[i];
            for (int i = 0; i < cubeh_pkg::HALF_WORDS; i++)
                tmp[i ^ swap_lo] = rotl(cube[i], rot);
            for (int i = 0; i < cubeh_pkg::HALF_WORDS; i++)
                cube[i] = tmp[i] ^ cube[i + cubeh_pkg::HALF_WORDS];
            for (int i = 0; i < cubeh_pkg::HALF_WORDS; i++)
                tmp[i ^ swap_hi] = cube[i + cubeh_pkg::HALF_WORDS];
            for (int i = 0; i < cubeh_pkg::HALF_WORDS; i++)
                cube[i + cubeh_pkg::HALF_WORDS] = tmp[i];
        endfunction

        function void run_rounds(int unsigned n);
            for (int unsigned r = 0; r < n; r++) begin
                half_round(cubeh_pkg::ROT_A, cubeh_pkg::SWAP_LO_A, cubeh_pkg::SWAP_HI_A);
                half_round(cubeh_pkg::ROT_B, cubeh_pkg::SWAP_LO_B, cubeh_pkg::SWAP_HI_B);
            end
        endfunction

        function void load_iv();
            for (int i = 0; i < cubeh_pkg::CUBE_WORDS; i++)
                cube[i] = '0;
            cube[0] = cubeh_pkg::IV_W0;
            cube[1] = cubeh_pkg::IV_W1;
            cube[2] = cubeh_pkg::IV_W2;
            run_rounds(IV_ROUNDS);
        endfunction

        function void note_input(cubeh_pkg::t_in_item it);
            cubeh_pkg::t_out_item d;
            if (it.cmd == cubeh_pkg::CMD_ABSORB) begin
                cube[0][7:0] ^= it.msg_byte;
                run_rounds(1);
            end else begin
                cube[0][7:0] ^= cubeh_pkg::PAD_BYTE;
                run_rounds(1);
                cube[31][0] ^= 1'b1;
                run_rounds(FINAL_ROUNDS);
                d.digest_word0 = {cube[1], cube[0]};
                d.digest_word1 = {cube[3], cube[2]};
                d.digest_word2 = {cube[5], cube[4]};
                d.digest_word3 = {cube[7], cube[6]};
                pending.push_back(d);
                load_iv();
            end
        endfunction

        task report(string msg);
            if (errors < PRINT_CAP)
                $display("%0t mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_digest(cubeh_pkg::t_out_item got);
            cubeh_pkg::t_out_item want;
            if (pending.size() == 0) begin
                report($sformatf("digest with none expected: %h", got));
            end else begin
                want = pending.pop_front();
                if (got.digest_word0 !== want.digest_word0)
                    report($sformatf("digest_word0 got %h want %h",
                                     got.digest_word0, want.digest_word0));
                if (got.digest_word1 !== want.digest_word1)
                    report($sformatf("digest_word1 got %h want %h",
                                     got.digest_word1, want.digest_word1));
                if (got.digest_word2 !== want.digest_word2)
                    report($sformatf("digest_word2 got %h want %h",
                                     got.digest_word2, want.digest_word2));
                if (got.digest_word3 !== want.digest_word3)
                    report($sformatf("digest_word3 got %h want %h",
                                     got.digest_word3, want.digest_word3));
            end
        endtask
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    cubeh_pkg::t_in_item  i_in_data   = '0;
    logic                 i_out_stall = 1'b0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    cubeh_pkg::t_out_item o_out_data;

    digest_scoreboard sb = new();

    int unsigned snd_idle_pct = 0;
    int unsigned rcv_idle_pct = 0;
    int unsigned hold_reqs    = 0;
    int unsigned hold_done    = 0;
    int unsigned hold_left    = 0;
    int unsigned idle_cycles  = 0;
    int unsigned items_sent   = 0;

    wire in_fire  = i_rst_n && i_in_valid && !o_in_stall;
    wire out_fire = i_rst_n && o_out_valid && !i_out_stall;

    cubehash_r1_b1_256 dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (in_fire)
            sb.note_input(i_in_data);
        if (out_fire)
            sb.check_digest(o_out_data);
    end

    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_done != hold_reqs) begin
            i_out_stall <= 1'b1;
            hold_left   <= HOLD_CYCLES - 1;
            hold_done   <= hold_done + 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rcv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (in_fire || out_fire)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_item(input logic cmd, input logic [7:0] msg_byte);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid         <= 1'b1;
        i_in_data.cmd      <= cmd;
        i_in_data.msg_byte <= msg_byte;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_message(input int unsigned len);
        for (int unsigned k = 0; k < len; k++)
            send_item(cubeh_pkg::CMD_ABSORB, 8'($urandom_range(255)));
        send_item(cubeh_pkg::CMD_FINISH, 8'($urandom_range(255)));
    endtask

    task automatic run_phase(input int unsigned snd_pct, input int unsigned rcv_pct,
                             input int unsigned quota);
        int unsigned stop_at;
        stop_at      = items_sent + quota;
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        hold_reqs    = hold_reqs + 1;
        while (items_sent < stop_at) begin
            if ($urandom_range(99) < 85) begin
                if ($urandom_range(99) < 80)
                    send_message($urandom_range(6));
                else
                    send_message($urandom_range(40, 7));
            end else begin
                send_item(($urandom_range(3) == 0) ? cubeh_pkg::CMD_FINISH
                                                   : cubeh_pkg::CMD_ABSORB,
                          8'($urandom_range(255)));
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        snd_idle_pct = 22;
        rcv_idle_pct = 72;
        send_item(cubeh_pkg::CMD_FINISH, 8'h00);
        send_item(cubeh_pkg::CMD_FINISH, 8'hff);
        send_item(cubeh_pkg::CMD_ABSORB, 8'h00);
        send_item(cubeh_pkg::CMD_FINISH, 8'h00);
        send_item(cubeh_pkg::CMD_ABSORB, 8'hff);
        send_item(cubeh_pkg::CMD_FINISH, 8'h5a);
        send_item(cubeh_pkg::CMD_ABSORB, 8'h80);
        send_item(cubeh_pkg::CMD_ABSORB, 8'h01);
        send_item(cubeh_pkg::CMD_ABSORB, 8'h55);
        send_item(cubeh_pkg::CMD_ABSORB, 8'haa);
        send_item(cubeh_pkg::CMD_ABSORB, 8'h7f);
        send_item(cubeh_pkg::CMD_FINISH, 8'h80);
        send_item(cubeh_pkg::CMD_ABSORB, 8'hff);
        send_item(cubeh_pkg::CMD_ABSORB, 8'hff);
        send_item(cubeh_pkg::CMD_ABSORB, 8'hff);
        send_item(cubeh_pkg::CMD_FINISH, 8'hff);
        send_item(cubeh_pkg::CMD_FINISH, 8'h00);

        run_phase(22, 72, ITEM_TARGET / 3);
        run_phase(72, 22, ITEM_TARGET / 3);
        run_phase(0, 0, ITEM_TARGET / 3);

        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
design/cubeh_pkg.sv
design/cubeh_half_round.sv
design/cubehash_r1_b1_256.sv
tb/tb_cubehash_r1_b1_256.sv
